// ===== rtl/jde_pkg.sv =====
// Shared types, constants and event-order tables for the joystick d-pad encoder.
`timescale 1ns / 1ps

package jde_pkg;

  // Field widths
  localparam int unsigned SampleW  = 14;
  localparam int unsigned GateW    = 10;
  localparam int unsigned ThrW     = 12;
  localparam int unsigned OffW     = 16;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned NumKeys  = 8;

  // Default depth of the queue between classifier and serializer
  localparam int unsigned FIFO_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_SAMPLE_LIMIT  = 3'd2,
    CFG_NOISE_GATE    = 3'd3,
    CFG_DIR_THRESHOLD = 3'd4
  } cfg_idx_e;

  // Register reset values
  localparam logic [SampleW-1:0] CENTER_RESET = 14'd4200;
  localparam logic [SampleW-1:0] LIMIT_RESET  = 14'd8192;
  localparam logic [GateW-1:0]   GATE_RESET   = 10'd50;
  localparam logic [ThrW-1:0]    THR_RESET    = 12'd300;

  // Bit positions inside the button mask
  localparam int unsigned BIT_UP     = 0;
  localparam int unsigned BIT_DOWN   = 1;
  localparam int unsigned BIT_LEFT   = 2;
  localparam int unsigned BIT_RIGHT  = 3;
  localparam int unsigned BIT_A      = 4;
  localparam int unsigned BIT_B      = 5;
  localparam int unsigned BIT_SELECT = 6;
  localparam int unsigned BIT_START  = 7;

  // Key codes reported with an event
  typedef enum logic [CodeW-1:0] {
    KEY_UP    = 3'd0,
    KEY_DOWN  = 3'd1,
    KEY_LEFT  = 3'd2,
    KEY_RIGHT = 3'd3,
    KEY_K0    = 3'd4,
    KEY_K1    = 3'd5,
    KEY_K2    = 3'd6,
    KEY_K3    = 3'd7
  } key_code_e;

  // Event order: slot i reports mask bit ORDER_BIT[i] under code ORDER_CODE[i]
  localparam logic [CodeW-1:0] ORDER_BIT [NumKeys] = '{
    3'(BIT_UP), 3'(BIT_DOWN), 3'(BIT_LEFT), 3'(BIT_RIGHT),
    3'(BIT_A), 3'(BIT_B), 3'(BIT_START), 3'(BIT_SELECT)
  };
  localparam key_code_e ORDER_CODE [NumKeys] = '{
    KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_K2, KEY_K1, KEY_K3, KEY_K0
  };

  // One classified poll: its mask and the event slots still to report
  typedef struct packed {
    logic [MaskW-1:0]   mask;
    logic [NumKeys-1:0] pend;
  } job_t;

endpackage

// ===== rtl/jde_in_if.sv =====
// Poll channel: valid/ready handshake with the joystick and button sample fields.
`timescale 1ns / 1ps

interface jde_in_if;
  logic                         valid;
  logic                         ready;
  logic [jde_pkg::SampleW-1:0]  sample_x;
  logic                         x_read_ok;
  logic [jde_pkg::SampleW-1:0]  sample_y;
  logic                         y_read_ok;
  logic                         press_a;
  logic                         press_b;
  logic                         press_select;
  logic                         press_start;
  logic                         hold_events;

  modport source (
    output valid, sample_x, x_read_ok, sample_y, y_read_ok,
           press_a, press_b, press_select, press_start, hold_events,
    input  ready
  );
  modport sink (
    input  valid, sample_x, x_read_ok, sample_y, y_read_ok,
           press_a, press_b, press_select, press_start, hold_events,
    output ready
  );
endinterface

// ===== rtl/jde_out_if.sv =====
// Result channel: valid/ready handshake with mask and event fields.
`timescale 1ns / 1ps

interface jde_out_if;
  logic                        valid;
  logic                        ready;
  logic [jde_pkg::MaskW-1:0]   button_mask;
  logic                        event_valid;
  logic [jde_pkg::CodeW-1:0]   key_code;
  logic                        pressed;
  logic                        last_of_run;

  modport source (
    output valid, button_mask, event_valid, key_code, pressed, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, button_mask, event_valid, key_code, pressed, last_of_run,
    output ready
  );
endinterface

// ===== rtl/joystick_dpad_event_encoder_unit.sv =====
// Top level of the joystick d-pad encoder: classifier, job queue and event serializer.
//
//   channel   dir  handshake               payload
//   poll_i    in   poll_i.valid/ready      sample_x, x_read_ok, sample_y, y_read_ok,
//                                          press_a/b/select/start, hold_events
//   result_o  out  result_o.valid/ready    button_mask, event_valid, key_code,
//                                          pressed, last_of_run
//   cfg       in   cfg_we_i                cfg_idx_i, cfg_wdata_i (write only)
//
// A poll passes two front stages (offset, then gate/mask) and enters the job queue.
// The serializer emits one result per cycle while the output is accepted: one result per
// pending event of a poll (up to 8), or one plain result if none is pending. Polls keep entering
// while the queue has room. Reset clears offsets, reported mask, queue and output valid at once.
`timescale 1ns / 1ps

module joystick_dpad_event_encoder_unit #(
  parameter int unsigned FifoDepth = jde_pkg::FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jde_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [jde_pkg::CfgDataW-1:0]  cfg_wdata_i,
  jde_in_if.sink                        poll_i,
  jde_out_if.source                     result_o
);

  logic          push, full, pop, empty;
  jde_pkg::job_t job, head;

  jde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .poll_i      (poll_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job)
  );

  jde_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  jde_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

// ===== rtl/jde_front.sv =====
// Front end: configuration registers, sample cleanup, noise gate and mask classification.
`timescale 1ns / 1ps

module jde_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jde_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [jde_pkg::CfgDataW-1:0]  cfg_wdata_i,
  jde_in_if.sink                        poll_i,
  input  logic                          full_i,
  output logic                          push_o,
  output jde_pkg::job_t                 job_o
);

  localparam int unsigned SW = jde_pkg::SampleW;
  localparam int unsigned OW = jde_pkg::OffW;
  localparam int unsigned TW = jde_pkg::ThrW;
  localparam int unsigned GW = jde_pkg::GateW;
  localparam int unsigned MW = jde_pkg::MaskW;
  localparam int unsigned NK = jde_pkg::NumKeys;

  // Keep a fresh offset when it moved at least the gate, else keep the held one
  function automatic logic [OW-1:0] gate_off(logic signed [SW:0] fresh,
                                             logic [OW-1:0] held,
                                             logic [GW-1:0] ng);
    logic signed [OW:0] diff;
    logic [OW:0]        mag;
    diff = $signed({{(OW-SW){fresh[SW]}}, fresh}) - $signed({held[OW-1], held});
    mag  = diff[OW] ? $unsigned(-diff) : $unsigned(diff);
    if (mag < {{(OW+1-GW){1'b0}}, ng}) begin
      return held;
    end
    return {{(OW-SW-1){fresh[SW]}}, fresh};
  endfunction

  // Direction bits of one axis: {positive, negative} beyond the threshold
  function automatic logic [1:0] dir_bits(logic [OW-1:0] off, logic [TW-1:0] thr);
    logic signed [OW:0] o;
    logic signed [OW:0] t;
    o = $signed({off[OW-1], off});
    t = $signed({{(OW+1-TW){1'b0}}, thr});
    return {(o > t), (o < -t)};
  endfunction

  // Configuration registers
  logic [SW-1:0] center_x_q, center_y_q, limit_q;
  logic [GW-1:0] gate_q;
  logic [TW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= jde_pkg::CENTER_RESET;
      center_y_q <= jde_pkg::CENTER_RESET;
      limit_q    <= jde_pkg::LIMIT_RESET;
      gate_q     <= jde_pkg::GATE_RESET;
      thr_q      <= jde_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jde_pkg::CFG_CENTER_X:      center_x_q <= cfg_wdata_i[SW-1:0];
        jde_pkg::CFG_CENTER_Y:      center_y_q <= cfg_wdata_i[SW-1:0];
        jde_pkg::CFG_SAMPLE_LIMIT:  limit_q    <= cfg_wdata_i[SW-1:0];
        jde_pkg::CFG_NOISE_GATE:    gate_q     <= cfg_wdata_i[GW-1:0];
        jde_pkg::CFG_DIR_THRESHOLD: thr_q      <= cfg_wdata_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // Stage A: replace bad samples by the center and form raw offsets
  logic               a_valid_q;
  logic signed [SW:0] fresh_x_q, fresh_y_q, fresh_x_d, fresh_y_d;
  logic [3:0]         btn_q;
  logic               hold_q;
  logic [SW-1:0]      sx_use, sy_use;
  logic               a_take, b_fire;

  always_comb begin
    sx_use = (!poll_i.x_read_ok || (poll_i.sample_x > limit_q)) ? center_x_q
                                                                : poll_i.sample_x;
    sy_use = (!poll_i.y_read_ok || (poll_i.sample_y > limit_q)) ? center_y_q
                                                                : poll_i.sample_y;
    fresh_x_d = $signed({1'b0, sx_use}) - $signed({1'b0, center_x_q});
    fresh_y_d = $signed({1'b0, center_y_q}) - $signed({1'b0, sy_use});
  end

  assign b_fire       = a_valid_q && !full_i;
  assign poll_i.ready = !a_valid_q || b_fire;
  assign a_take       = poll_i.valid && poll_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      a_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      fresh_x_q <= fresh_x_d;
      fresh_y_q <= fresh_y_d;
      btn_q     <= {poll_i.press_start, poll_i.press_select, poll_i.press_b, poll_i.press_a};
      hold_q    <= poll_i.hold_events;
    end
  end

  // Stage B: noise gate against held offsets, build mask and pending events
  logic [OW-1:0] held_x_q, held_y_q, filt_x, filt_y;
  logic [MW-1:0] reported_q, mask, changed;
  logic [1:0]    dx, dy;

  always_comb begin
    filt_x = gate_off(fresh_x_q, held_x_q, gate_q);
    filt_y = gate_off(fresh_y_q, held_y_q, gate_q);
    dx     = dir_bits(filt_x, thr_q);
    dy     = dir_bits(filt_y, thr_q);
    mask   = '0;
    mask[jde_pkg::BIT_LEFT]  = dx[0];
    mask[jde_pkg::BIT_RIGHT] = dx[1];
    mask[jde_pkg::BIT_UP]    = dy[0];
    mask[jde_pkg::BIT_DOWN]  = dy[1];
    mask[jde_pkg::BIT_A]      = btn_q[0];
    mask[jde_pkg::BIT_B]      = btn_q[1];
    mask[jde_pkg::BIT_SELECT] = btn_q[2];
    mask[jde_pkg::BIT_START]  = btn_q[3];
    changed    = mask ^ reported_q;
    job_o.mask = mask;
    for (int i = 0; i < NK; i++) begin
      job_o.pend[i] = !hold_q && changed[jde_pkg::ORDER_BIT[i]];
    end
  end

  assign push_o = b_fire;

  // On each push update held offsets, reported mask only outside hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q   <= '0;
      held_y_q   <= '0;
      reported_q <= '0;
    end else if (b_fire) begin
      held_x_q <= filt_x;
      held_y_q <= filt_y;
      if (!hold_q) begin
        reported_q <= mask;
      end
    end
  end

endmodule

// ===== rtl/jde_fifo.sv =====
// Short job queue between the classifier and the event serializer.
`timescale 1ns / 1ps

module jde_fifo #(
  parameter int unsigned Depth = jde_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jde_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jde_pkg::job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jde_pkg::job_t   entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  // Store incoming job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("jde_fifo: push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("jde_fifo: pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("jde_fifo: occupancy beyond depth");
`endif

endmodule

// ===== rtl/jde_back.sv =====
// Back end: serializes queue head to output register, one event per cycle when accepted.
`timescale 1ns / 1ps

module jde_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jde_pkg::job_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  jde_out_if.source     result_o
);

  localparam int unsigned NK = jde_pkg::NumKeys;
  localparam int unsigned SlotW = $clog2(NK);

  logic [NK-1:0]          done_q, done_d, rem, slot_oh;
  logic [SlotW-1:0]       slot;
  logic                   has_ev, last, load;
  logic                   out_valid_q, out_ev_q, out_pr_q, out_last_q;
  logic [jde_pkg::MaskW-1:0] out_mask_q;
  jde_pkg::key_code_e     out_code_q;

  // Pick the first event slot not yet reported
  always_comb begin
    rem     = head_i.pend & ~done_q;
    has_ev  = |rem;
    slot    = '0;
    slot_oh = '0;
    for (int i = NK - 1; i >= 0; i--) begin
      if (rem[i]) begin
        slot = SlotW'(i);
      end
    end
    if (has_ev) begin
      slot_oh[slot] = 1'b1;
    end
    last = ((rem & ~slot_oh) == '0);
  end

  assign load  = !empty_i && (!out_valid_q || result_o.ready);
  assign pop_o = load && last;

  always_comb begin
    done_d = done_q;
    if (load) begin
      done_d = last ? '0 : (done_q | slot_oh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_mask_q <= head_i.mask;
      out_ev_q   <= has_ev;
      out_code_q <= has_ev ? jde_pkg::ORDER_CODE[slot] : jde_pkg::KEY_UP;
      out_pr_q   <= has_ev && head_i.mask[jde_pkg::ORDER_BIT[slot]];
      out_last_q <= last;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.button_mask = out_mask_q;
  assign result_o.event_valid = out_ev_q;
  assign result_o.key_code    = out_code_q;
  assign result_o.pressed     = out_pr_q;
  assign result_o.last_of_run = out_last_q;

`ifndef SYNTHESIS
  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ev_q) |-> out_last_q)
    else $error("jde_back: non-event result not marked last");
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (done_q == '0))
    else $error("jde_back: progress not cleared after pop");
  a_head_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !last) |=> !empty_i)
    else $error("jde_back: queue head lost in the middle of a run");
`endif

endmodule
